[rtl/vlmd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlmd_pkg
// Shared types and constants of the volume local maximum detector.
// ----------------------------------------------------------------------------
package vlmd_pkg;

   localparam int VLMD_MAX_X = 128;
   localparam int VLMD_MAX_Y = 128;
   localparam int VLMD_MAX_Z = 1024;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_X    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Y    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Z    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd3;

   typedef struct packed {
      logic               action;
      logic signed [31:0] density;
   } req_type;

   typedef struct packed {
      logic [23:0]        voxel_index;
      logic signed [31:0] centre_value;
      logic               is_peak;
      logic               is_final;
   } rsp_type;

   // one stored voxel slot; ok clear for drained or out-of-volume slots
   typedef struct packed {
      logic               ok;
      logic signed [31:0] value;
   } slot_type;

endpackage

[rtl/volume_local_maximum_detector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// volume_local_maximum_detector
// Streaming 3x3x3 local maximum finder over a raster-order voxel stream.
// Slot triples (voxel plus its two predecessors) are kept in row, plane and
// two-plane delay memories; one registered read per window row feeds the
// 26-neighbour compare.
// ----------------------------------------------------------------------------
//   channel | signals                          | beat
//   req     | req_valid, req_stall, req_data   | one voxel or drain tick
//   rsp     | rsp_valid, rsp_stall, rsp_data   | one centre result
//   csr     | csr_valid, csr_ready, csr_index, | one register write
//           | csr_data                         |
//
// One req beat per cycle while req_stall is low; each result passes the compare
// stage register and then the output register. After reset and after every csr
// write the req side stalls while the plane and volume products and the serial
// PW-bit divide (PW = position width, 25 at defaults) that recovers the centre
// coordinates run. Reset is synchronous; the delay memories are not cleared, a
// fill count marks what was written. rsp_stall holds the output register; req
// then stalls only when the compare stage is also full.
// ----------------------------------------------------------------------------
module volume_local_maximum_detector #(
   parameter int MAX_X = vlmd_pkg::VLMD_MAX_X,
   parameter int MAX_Y = vlmd_pkg::VLMD_MAX_Y,
   parameter int MAX_Z = vlmd_pkg::VLMD_MAX_Z
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  vlmd_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output vlmd_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [vlmd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [vlmd_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int XW  = $clog2(MAX_X + 1);
   localparam int YW  = $clog2(MAX_Y + 1);
   localparam int ZW  = $clog2(MAX_Z + 1);
   localparam int SXW = (XW > 8) ? XW : 8;
   localparam int SYW = (YW > 8) ? YW : 8;
   localparam int SZW = (ZW > 11) ? ZW : 11;
   localparam int DW  = (XW > YW) ? XW : YW;
   localparam int MAX_PLANE = MAX_X * MAX_Y;
   localparam int PLW = $clog2(MAX_PLANE + 1);
   localparam longint MAX_TOTAL = longint'(MAX_PLANE) * longint'(MAX_Z);
   localparam longint MAX_LAG   = longint'(MAX_PLANE + MAX_X + 1);
   localparam int TW  = $clog2(MAX_TOTAL + 1);
   localparam int PW  = $clog2(MAX_TOTAL + MAX_LAG);
   localparam int CNTW = $clog2(PW + 1);
   localparam int DR  = 2 * MAX_X + 1;
   localparam int DM  = MAX_PLANE + MAX_X + 1;
   localparam int DF  = 2 * MAX_PLANE + 2 * MAX_X + 1;
   localparam int RAW = $clog2(DR);
   localparam int MAW = $clog2(DM);
   localparam int FAW = $clog2(DF);
   localparam int BW  = $clog2(DF);

   typedef enum logic [5:0] {
      ST_RUN   = 6'b000001,
      ST_PLANE = 6'b000010,
      ST_TOTAL = 6'b000100,
      ST_LOAD  = 6'b001000,
      ST_DIVX  = 6'b010000,
      ST_DIVY  = 6'b100000
   } state_type;

   typedef vlmd_pkg::slot_type [2:0] word_type;

   function automatic logic [BW:0] back_addr(input logic [BW:0] wp,
                                             input logic [BW-1:0] b,
                                             input logic [BW:0] depth);
      logic [BW:0] s;
      s = wp + depth - {1'b0, b};
      if (s >= depth) s = s - depth;
      return s;
   endfunction

   // configuration and derived geometry
   state_type          state_ff;
   logic [7:0]         size_x_ff, size_y_ff;
   logic [10:0]        size_z_ff;
   logic signed [31:0] threshold_ff;
   logic [XW-1:0]      sx_c, sx_ff, sx_m1_ff;
   logic [YW-1:0]      sy_c, sy_ff, sy_m1_ff;
   logic [ZW-1:0]      sz_c, sz_m1_ff;
   logic [SXW-1:0]     raw_x;
   logic [SYW-1:0]     raw_y;
   logic [SZW-1:0]     raw_z;
   logic [XW+YW-1:0]   plane_prod;
   logic [PLW+ZW-1:0]  total_prod;
   logic [PLW-1:0]     plane_ff;
   logic [ZW-1:0]      sz_ff;
   logic [TW-1:0]      total_m1_ff;
   logic [BW-1:0]      lag_ff;
   logic [BW-1:0]      b01_ff, b02_ff, b10_ff, b11_ff, b12_ff, b20_ff, b21_ff, b22_ff;
   logic               csr_wr;

   // coordinate recovery divider
   logic [PW-1:0]      div_num_ff;
   logic [DW-1:0]      div_rem_ff;
   logic [CNTW-1:0]    div_cnt_ff;
   logic [DW-1:0]      div_d;
   logic [DW:0]        div_r2;
   logic               div_ge;
   logic [DW-1:0]      div_rem_in;
   logic [PW-1:0]      div_num_in;
   logic               div_last;

   // stream position
   logic [PW-1:0]      p_ff, p_in;
   logic [XW-1:0]      cx_ff, cx_in;
   logic [YW-1:0]      cy_ff, cy_in;
   logic [ZW-1:0]      cz_ff, cz_in;
   logic [PW-1:0]      lag_ext, tot_ext, c_pos;
   logic               accept, pre, over, res, fin, present;
   logic [BW-1:0]      fill_ff;
   logic [RAW-1:0]     wr_row_ff;
   logic [MAW-1:0]     wr_mid_ff;
   logic [FAW-1:0]     wr_full_ff;
   vlmd_pkg::slot_type prev1_ff, prev2_ff, cur_slot;
   word_type           wr_word;
   logic [RAW-1:0]     row_a0, row_a1;
   logic [MAW-1:0]     mid_a0, mid_a1;
   logic [FAW-1:0]     fa_a0, fa_a1, fb_a0, fb_a1;

   // delay memories and read registers
   word_type           mem_row_ff [DR];
   word_type           mem_mid_ff [DM];
   word_type           mem_fa_ff  [DF];
   word_type           mem_fb_ff  [DF];
   word_type           row_rd0_ff, row_rd1_ff, mid_rd0_ff, mid_rd1_ff;
   word_type           fa_rd0_ff, fa_rd1_ff, fb_rd0_ff, fb_rd1_ff;

   // compare stage
   logic               s1_valid_ff, s1_move;
   logic [23:0]        s1_index_ff;
   logic               s1_final_ff;
   logic [2:0]         s1_xok_ff, s1_yok_ff, s1_zok_ff;
   word_type           s1_cur_ff;
   logic [2:0][2:0]    s1_wv_ff, wv_in;
   word_type           win [3][3];
   logic               c_ok, peak;
   logic signed [31:0] c_val;
   vlmd_pkg::slot_type nb;

   logic               rsp_valid_ff;
   vlmd_pkg::rsp_type  rsp_data_ff;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid & csr_ready;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff    <= 8'd128;
         size_y_ff    <= 8'd128;
         size_z_ff    <= 11'd128;
         threshold_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_index)
            vlmd_pkg::CSR_SIZE_X:    size_x_ff    <= csr_data[7:0];
            vlmd_pkg::CSR_SIZE_Y:    size_y_ff    <= csr_data[7:0];
            vlmd_pkg::CSR_SIZE_Z:    size_z_ff    <= csr_data[10:0];
            vlmd_pkg::CSR_THRESHOLD: threshold_ff <= csr_data;
         endcase
      end
   end

   always_comb begin
      raw_x = SXW'(size_x_ff);
      raw_y = SYW'(size_y_ff);
      raw_z = SZW'(size_z_ff);
      if (raw_x == '0)                 sx_c = XW'(1);
      else if (raw_x > SXW'(MAX_X))    sx_c = XW'(MAX_X);
      else                             sx_c = XW'(raw_x);
      if (raw_y == '0)                 sy_c = YW'(1);
      else if (raw_y > SYW'(MAX_Y))    sy_c = YW'(MAX_Y);
      else                             sy_c = YW'(raw_y);
      if (raw_z == '0)                 sz_c = ZW'(1);
      else if (raw_z > SZW'(MAX_Z))    sz_c = ZW'(MAX_Z);
      else                             sz_c = ZW'(raw_z);
      plane_prod = (XW+YW)'(sx_c) * (XW+YW)'(sy_c);
      total_prod = (PLW+ZW)'(plane_ff) * (PLW+ZW)'(sz_ff);
   end

   // ---------------- divider step ----------------
   always_comb begin
      div_d      = (state_ff == ST_DIVX) ? DW'(sx_ff) : DW'(sy_ff);
      div_r2     = {div_rem_ff, div_num_ff[PW-1]};
      div_ge     = div_r2 >= {1'b0, div_d};
      div_rem_in = div_ge ? DW'(div_r2 - {1'b0, div_d}) : DW'(div_r2);
      div_num_in = {div_num_ff[PW-2:0], div_ge};
      div_last   = div_cnt_ff == CNTW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_PLANE;
      end else if (csr_wr) begin
         state_ff <= ST_PLANE;
      end else begin
         unique case (state_ff)
            ST_RUN:   state_ff <= ST_RUN;
            ST_PLANE: state_ff <= ST_TOTAL;
            ST_TOTAL: state_ff <= ST_LOAD;
            ST_LOAD:  state_ff <= ST_DIVX;
            ST_DIVX:  if (div_last) state_ff <= ST_DIVY;
            ST_DIVY:  if (div_last) state_ff <= ST_RUN;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_PLANE: begin
            sx_ff    <= sx_c;
            sy_ff    <= sy_c;
            sz_ff    <= sz_c;
            sx_m1_ff <= sx_c - XW'(1);
            sy_m1_ff <= sy_c - YW'(1);
            sz_m1_ff <= sz_c - ZW'(1);
            plane_ff <= PLW'(plane_prod);
         end
         ST_TOTAL: begin
            total_m1_ff <= TW'(total_prod - (PLW+ZW)'(1));
            lag_ff <= BW'(plane_ff) + BW'(sx_ff) + BW'(1);
            b01_ff <= BW'(sx_ff);
            b02_ff <= BW'(sx_ff) << 1;
            b10_ff <= BW'(plane_ff);
            b11_ff <= BW'(plane_ff) + BW'(sx_ff);
            b12_ff <= BW'(plane_ff) + (BW'(sx_ff) << 1);
            b20_ff <= BW'(plane_ff) << 1;
            b21_ff <= (BW'(plane_ff) << 1) + BW'(sx_ff);
            b22_ff <= (BW'(plane_ff) << 1) + (BW'(sx_ff) << 1);
         end
         ST_LOAD: begin
            div_num_ff <= (p_ff < PW'(lag_ff)) ? '0 : p_ff - PW'(lag_ff);
            div_rem_ff <= '0;
            div_cnt_ff <= CNTW'(PW);
         end
         ST_DIVX, ST_DIVY: begin
            if (div_last) begin
               div_num_ff <= div_num_in;
               div_rem_ff <= '0;
               div_cnt_ff <= CNTW'(PW);
            end else begin
               div_num_ff <= div_num_in;
               div_rem_ff <= div_rem_in;
               div_cnt_ff <= div_cnt_ff - CNTW'(1);
            end
         end
         ST_RUN: ;
      endcase
   end

   // ---------------- input side ----------------
   assign req_stall = (state_ff != ST_RUN) || (s1_valid_ff && !s1_move);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      lag_ext = PW'(lag_ff);
      tot_ext = PW'(total_m1_ff);
      pre     = p_ff < lag_ext;
      c_pos   = p_ff - lag_ext;
      over    = !pre && (c_pos > tot_ext);
      res     = !pre && !over;
      fin     = res && (c_pos == tot_ext);
      present = !req_data.action && (p_ff <= tot_ext);
      cur_slot.ok    = present;
      cur_slot.value = present ? req_data.density : '0;
      wr_word = {prev2_ff, prev1_ff, cur_slot};

      p_in  = p_ff + PW'(1);
      cx_in = cx_ff;
      cy_in = cy_ff;
      cz_in = cz_ff;
      if (!pre) begin
         if (over || fin) begin
            p_in  = '0;
            cx_in = '0;
            cy_in = '0;
            cz_in = '0;
         end else if (cx_ff != sx_m1_ff) begin
            cx_in = cx_ff + XW'(1);
         end else begin
            cx_in = '0;
            if (cy_ff != sy_m1_ff) begin
               cy_in = cy_ff + YW'(1);
            end else begin
               cy_in = '0;
               cz_in = cz_ff + ZW'(1);
            end
         end
      end

      // a word at back b exists once b earlier beats went in
      wv_in       = '1;
      wv_in[0][1] = b01_ff <= fill_ff;
      wv_in[0][2] = b02_ff <= fill_ff;
      wv_in[1][0] = b10_ff <= fill_ff;
      wv_in[1][1] = b11_ff <= fill_ff;
      wv_in[1][2] = b12_ff <= fill_ff;
      wv_in[2][0] = b20_ff <= fill_ff;
      wv_in[2][1] = b21_ff <= fill_ff;
      wv_in[2][2] = b22_ff <= fill_ff;

      row_a0 = RAW'(back_addr((BW+1)'(wr_row_ff), b01_ff, (BW+1)'(DR)));
      row_a1 = RAW'(back_addr((BW+1)'(wr_row_ff), b02_ff, (BW+1)'(DR)));
      mid_a0 = MAW'(back_addr((BW+1)'(wr_mid_ff), b10_ff, (BW+1)'(DM)));
      mid_a1 = MAW'(back_addr((BW+1)'(wr_mid_ff), b11_ff, (BW+1)'(DM)));
      fa_a0  = FAW'(back_addr((BW+1)'(wr_full_ff), b12_ff, (BW+1)'(DF)));
      fa_a1  = FAW'(back_addr((BW+1)'(wr_full_ff), b20_ff, (BW+1)'(DF)));
      fb_a0  = FAW'(back_addr((BW+1)'(wr_full_ff), b21_ff, (BW+1)'(DF)));
      fb_a1  = FAW'(back_addr((BW+1)'(wr_full_ff), b22_ff, (BW+1)'(DF)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_ff        <= '0;
         cx_ff       <= '0;
         cy_ff       <= '0;
         cz_ff       <= '0;
         fill_ff     <= '0;
         wr_row_ff   <= '0;
         wr_mid_ff   <= '0;
         wr_full_ff  <= '0;
         prev1_ff.ok <= 1'b0;
         prev2_ff.ok <= 1'b0;
      end else begin
         if (state_ff == ST_DIVX && div_last) begin
            cx_ff <= XW'(div_rem_in);
         end else if (state_ff == ST_DIVY && div_last) begin
            cy_ff <= YW'(div_rem_in);
            cz_ff <= ZW'(div_num_in);
         end else if (accept) begin
            p_ff       <= p_in;
            cx_ff      <= cx_in;
            cy_ff      <= cy_in;
            cz_ff      <= cz_in;
            fill_ff    <= (fill_ff == BW'(DF - 1)) ? fill_ff : fill_ff + BW'(1);
            wr_row_ff  <= (wr_row_ff == RAW'(DR - 1)) ? '0 : wr_row_ff + RAW'(1);
            wr_mid_ff  <= (wr_mid_ff == MAW'(DM - 1)) ? '0 : wr_mid_ff + MAW'(1);
            wr_full_ff <= (wr_full_ff == FAW'(DF - 1)) ? '0 : wr_full_ff + FAW'(1);
            prev1_ff   <= cur_slot;
            prev2_ff   <= prev1_ff;
         end
      end
   end

   // ---------------- delay memories ----------------
   always_ff @(posedge clock) begin
      if (accept) begin
         mem_row_ff[wr_row_ff] <= wr_word;
         row_rd0_ff <= mem_row_ff[row_a0];
         row_rd1_ff <= mem_row_ff[row_a1];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mem_mid_ff[wr_mid_ff] <= wr_word;
         mid_rd0_ff <= mem_mid_ff[mid_a0];
         mid_rd1_ff <= mem_mid_ff[mid_a1];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mem_fa_ff[wr_full_ff] <= wr_word;
         fa_rd0_ff <= mem_fa_ff[fa_a0];
         fa_rd1_ff <= mem_fa_ff[fa_a1];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mem_fb_ff[wr_full_ff] <= wr_word;
         fb_rd0_ff <= mem_fb_ff[fb_a0];
         fb_rd1_ff <= mem_fb_ff[fb_a1];
      end
   end

   // ---------------- compare stage ----------------
   assign s1_move = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= res;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_index_ff <= 24'(c_pos);
         s1_final_ff <= fin;
         // index 0 is the +1 side (smaller back distance), index 2 the -1 side
         s1_xok_ff   <= {cx_ff != '0, 1'b1, cx_ff != sx_m1_ff};
         s1_yok_ff   <= {cy_ff != '0, 1'b1, cy_ff != sy_m1_ff};
         s1_zok_ff   <= {cz_ff != '0, 1'b1, cz_ff != sz_m1_ff};
         s1_cur_ff   <= wr_word;
         s1_wv_ff    <= wv_in;
      end
   end

   always_comb begin
      win[0][0] = s1_cur_ff;
      win[0][1] = row_rd0_ff;
      win[0][2] = row_rd1_ff;
      win[1][0] = mid_rd0_ff;
      win[1][1] = mid_rd1_ff;
      win[1][2] = fa_rd0_ff;
      win[2][0] = fa_rd1_ff;
      win[2][1] = fb_rd0_ff;
      win[2][2] = fb_rd1_ff;

      c_ok  = s1_wv_ff[1][1] && win[1][1][1].ok;
      c_val = c_ok ? win[1][1][1].value : '0;
      peak  = c_ok && (c_val > threshold_ff);
      nb    = '0;
      for (int j = 0; j < 3; j++) begin
         for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
               nb = win[j][i][k];
               if (!(j == 1 && i == 1 && k == 1) && s1_zok_ff[j] && s1_yok_ff[i] &&
                   s1_xok_ff[k] && s1_wv_ff[j][i] && nb.ok && (nb.value > c_val)) begin
                  peak = 1'b0;
               end
            end
         end
      end
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_move) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_data_ff.voxel_index  <= s1_index_ff;
         rsp_data_ff.centre_value <= c_val;
         rsp_data_ff.is_peak      <= peak;
         rsp_data_ff.is_final     <= s1_final_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
